// ----- design/ic2p_pkg.sv -----
// Shared types, character codes and decode functions for the infix-to-postfix converter.
package ic2p_pkg;

    localparam int STACK_DEPTH = 3;
    localparam int CNT_W       = 2;
    localparam logic [CNT_W-1:0] STACK_FULL_CNT = CNT_W'(STACK_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam logic [QCNT_W-1:0] QUEUE_FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_ADD  = 2'd1;
    localparam logic [1:0] LVL_MUL  = 2'd2;
    localparam logic [1:0] LVL_POW  = 2'd3;

    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_LETTER,
        KIND_OP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] level;
        logic [7:0] ch;
        logic       last;
    } t_token;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    function automatic logic [1:0] op_level(input logic [7:0] c);
        logic [1:0] lvl;
        unique case (c)
            CH_CARET:           lvl = LVL_POW;
            CH_STAR, CH_SLASH:  lvl = LVL_MUL;
            CH_PLUS, CH_MINUS:  lvl = LVL_ADD;
            default:            lvl = LVL_NONE;
        endcase
        return lvl;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

endpackage

// ----- design/ic2p_front.sv -----
// Front end: classify incoming characters and hold them in a short token queue.
module ic2p_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_in_char,
    input  logic                 i_end_of_input,
    output logic                 o_tok_valid,
    output ic2p_pkg::t_token     o_tok,
    input  logic                 i_tok_take
);

    ic2p_pkg::t_token                 r_q [0:ic2p_pkg::QUEUE_DEPTH-1];
    logic [ic2p_pkg::QPTR_W-1:0]      r_wr;
    logic [ic2p_pkg::QPTR_W-1:0]      r_rd;
    logic [ic2p_pkg::QCNT_W-1:0]      r_qcnt;
    logic [ic2p_pkg::QCNT_W-1:0]      n_qcnt;
    ic2p_pkg::t_token                 in_tok;
    logic [1:0]                       in_lvl;
    logic                             wr_en;
    logic                             rd_en;

    always_comb begin
        in_lvl      = ic2p_pkg::op_level(i_in_char);
        in_tok.ch   = i_in_char;
        in_tok.last = i_end_of_input;
        in_tok.level = in_lvl;
        if (ic2p_pkg::is_letter(i_in_char)) begin
            in_tok.kind = ic2p_pkg::KIND_LETTER;
        end else if (in_lvl != ic2p_pkg::LVL_NONE) begin
            in_tok.kind = ic2p_pkg::KIND_OP;
        end else begin
            in_tok.kind = ic2p_pkg::KIND_DROP;
        end
    end

    assign o_full      = (r_qcnt == ic2p_pkg::QUEUE_FULL_CNT);
    assign o_tok_valid = (r_qcnt != '0);
    assign o_tok       = r_q[r_rd];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_tok_take && o_tok_valid;

    always_comb begin
        n_qcnt = r_qcnt;
        if (wr_en && !rd_en) begin
            n_qcnt = r_qcnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_qcnt = r_qcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_qcnt <= '0;
        end else begin
            r_qcnt <= n_qcnt;
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= in_tok;
        end
    end

`ifndef ASSERT_OFF
    a_qcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= ic2p_pkg::QUEUE_FULL_CNT)
        else $error("token queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qcnt == '0 || r_qcnt == ic2p_pkg::QUEUE_FULL_CNT) |-> (r_wr == r_rd))
        else $error("token queue pointers disagree with count");
    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_qcnt != ic2p_pkg::QUEUE_FULL_CNT) || $past(wr_en))
        else $error("token queue count did not drop after take");
`endif

endmodule

// ----- design/ic2p_back.sv -----
// Back end: operator stack sequencer and result register.
module ic2p_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tok_valid,
    input  ic2p_pkg::t_token     i_tok,
    output logic                 o_tok_take,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [7:0]           o_out_char,
    output logic                 o_char_valid,
    output logic                 o_end_of_expression,
    output logic                 o_last_of_run
);

    ic2p_pkg::t_state             r_state;
    ic2p_pkg::t_state             n_state;
    ic2p_pkg::t_token             r_tok;
    logic [7:0]                   r_stack [0:ic2p_pkg::STACK_DEPTH-1];
    logic [ic2p_pkg::CNT_W-1:0]   r_cnt;
    logic                         r_ov;
    logic [7:0]                   r_out_char;
    logic                         r_cv;
    logic                         r_eoe;
    logic                         r_lor;

    logic [ic2p_pkg::CNT_W-1:0]   top_idx;
    logic [7:0]                   top_ch;
    logic                         top_ge;
    logic [7:0]                   sec_ch;
    logic                         sec_ge;
    logic                         stk_empty;
    logic                         out_ready;
    logic                         act_emit;
    logic                         act_pop;
    logic                         act_push;
    logic [7:0]                   em_char;
    logic                         em_cv;
    logic                         em_eoe;
    logic                         em_lor;

    always_comb begin
        top_idx   = r_cnt - 1'b1;
        stk_empty = (r_cnt == '0);
        top_ch    = stk_empty ? ic2p_pkg::CH_NUL : r_stack[top_idx];
        top_ge    = !stk_empty && (ic2p_pkg::op_level(top_ch) >= r_tok.level);
        // entry below the top decides whether the current pop ends the run
        sec_ch    = (r_cnt >= 2'd2) ? r_stack[r_cnt - 2'd2] : ic2p_pkg::CH_NUL;
        sec_ge    = (r_cnt >= 2'd2) && (ic2p_pkg::op_level(sec_ch) >= r_tok.level);
        out_ready = !r_ov || i_pop;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ic2p_pkg::ST_IDLE: begin
                if (i_tok_valid) begin
                    n_state = ic2p_pkg::ST_RUN;
                end
            end
            ic2p_pkg::ST_RUN: begin
                case (r_tok.kind)
                    ic2p_pkg::KIND_LETTER: begin
                        if (out_ready) begin
                            n_state = (r_tok.last && !stk_empty) ? ic2p_pkg::ST_FLUSH
                                                                 : ic2p_pkg::ST_IDLE;
                        end
                    end
                    ic2p_pkg::KIND_OP: begin
                        if (!top_ge) begin
                            n_state = r_tok.last ? ic2p_pkg::ST_FLUSH : ic2p_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        if (!r_tok.last) begin
                            n_state = ic2p_pkg::ST_IDLE;
                        end else if (!stk_empty) begin
                            n_state = ic2p_pkg::ST_FLUSH;
                        end else if (out_ready) begin
                            n_state = ic2p_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            ic2p_pkg::ST_FLUSH: begin
                if (out_ready && r_cnt == 2'd1) begin
                    n_state = ic2p_pkg::ST_IDLE;
                end
            end
            default: n_state = ic2p_pkg::ST_IDLE;
        endcase
    end

    // actions and result fields
    always_comb begin
        o_tok_take = 1'b0;
        act_emit   = 1'b0;
        act_pop    = 1'b0;
        act_push   = 1'b0;
        em_char    = ic2p_pkg::CH_NUL;
        em_cv      = 1'b0;
        em_eoe     = 1'b0;
        em_lor     = 1'b0;
        unique case (r_state)
            ic2p_pkg::ST_IDLE: begin
                o_tok_take = i_tok_valid;
            end
            ic2p_pkg::ST_RUN: begin
                case (r_tok.kind)
                    ic2p_pkg::KIND_LETTER: begin
                        act_emit = out_ready;
                        em_char  = r_tok.ch;
                        em_cv    = 1'b1;
                        em_eoe   = r_tok.last && stk_empty;
                        em_lor   = !r_tok.last || stk_empty;
                    end
                    ic2p_pkg::KIND_OP: begin
                        if (top_ge) begin
                            // pop one stacked operator; the push still follows
                            act_emit = out_ready;
                            act_pop  = out_ready;
                            em_char  = top_ch;
                            em_cv    = 1'b1;
                            em_lor   = !r_tok.last && !sec_ge;
                        end else begin
                            act_push = 1'b1;
                        end
                    end
                    default: begin
                        if (r_tok.last && stk_empty) begin
                            act_emit = out_ready;
                            em_eoe   = 1'b1;
                            em_lor   = 1'b1;
                        end
                    end
                endcase
            end
            ic2p_pkg::ST_FLUSH: begin
                act_emit = out_ready;
                act_pop  = out_ready;
                em_char  = top_ch;
                em_cv    = 1'b1;
                em_eoe   = (r_cnt == 2'd1);
                em_lor   = (r_cnt == 2'd1);
            end
            default: begin
                act_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ic2p_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (act_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end else if (act_push && r_cnt != ic2p_pkg::STACK_FULL_CNT) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (act_emit) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_take) begin
            r_tok <= i_tok;
        end
        if (act_push && r_cnt != ic2p_pkg::STACK_FULL_CNT) begin
            r_stack[r_cnt] <= r_tok.ch;
        end
        if (act_emit) begin
            r_out_char <= em_char;
            r_cv       <= em_cv;
            r_eoe      <= em_eoe;
            r_lor      <= em_lor;
        end
    end

    assign o_empty             = !r_ov;
    assign o_out_char          = r_out_char;
    assign o_char_valid        = r_cv;
    assign o_end_of_expression = r_eoe;
    assign o_last_of_run       = r_lor;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ic2p_pkg::STACK_FULL_CNT)
        else $error("operator stack overflow");
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        act_emit |-> (!r_ov || i_pop))
        else $error("result written over an unread result");
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ic2p_pkg::ST_FLUSH) |-> !stk_empty)
        else $error("flush with empty stack");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (act_emit && em_eoe) |=> (r_cnt == '0 && r_state == ic2p_pkg::ST_IDLE))
        else $error("stack not empty after end of expression");
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        act_push |-> (r_cnt != ic2p_pkg::STACK_FULL_CNT))
        else $error("push onto a full stack");
`endif

endmodule

// ----- design/infix_to_postfix_converter.sv -----
// A request is queued, loaded into the token register, then written to the result register.
// The back end loads a new request only after it has finished the last one, pops included.
// A request that emits nothing and is not the end of input still occupies the back end.
// The classify queue holds 2 requests and the back end loads one more while a result waits.
// Reset (synchronous, active low) empties the queue, the operator stack and the result register.
module infix_to_postfix_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_input,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_end_of_expression,
    output logic       o_last_of_run
);

    logic              tok_valid;
    logic              tok_take;
    ic2p_pkg::t_token  tok;

    ic2p_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_in_char      (i_in_char),
        .i_end_of_input (i_end_of_input),
        .o_tok_valid    (tok_valid),
        .o_tok          (tok),
        .i_tok_take     (tok_take)
    );

    ic2p_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_tok_valid         (tok_valid),
        .i_tok               (tok),
        .o_tok_take          (tok_take),
        .o_empty             (o_empty),
        .i_pop               (i_pop),
        .o_out_char          (o_out_char),
        .o_char_valid        (o_char_valid),
        .o_end_of_expression (o_end_of_expression),
        .o_last_of_run       (o_last_of_run)
    );

endmodule
